>>> rtl/cts_pkg.sv
package cts_pkg;

	// operation codes on op
	localparam logic [2:0] OP_INSERT    = 3'd0;
	localparam logic [2:0] OP_DELETE    = 3'd1;
	localparam logic [2:0] OP_INORDER   = 3'd2;
	localparam logic [2:0] OP_PREORDER  = 3'd3;
	localparam logic [2:0] OP_POSTORDER = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// walker phases: arrived from parent, back from left child, back from right child
	localparam logic [1:0] PH_DOWN       = 2'd0;
	localparam logic [1:0] PH_FROM_LEFT  = 2'd1;
	localparam logic [1:0] PH_FROM_RIGHT = 2'd2;

	typedef struct packed {
		logic accept;    // transfer of a new item this cycle
		logic walk_run;  // advance the walker one phase
		logic flush;     // release the held value as the final result
	} cts_cmd_t;

	typedef struct packed {
		logic cnt_zero;  // tree is empty
		logic walk_done; // walker is leaving the root this cycle
	} cts_stat_t;

endpackage

>>> rtl/cts_ram.sv
module cts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/cts_ctrl.sv
module cts_ctrl
	import cts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [2:0] op,
	input  cts_stat_t stat,
	output cts_cmd_t  cmd,
	output logic      busy
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       is_trav;

	assign is_trav = (op == OP_INORDER) || (op == OP_PREORDER) || (op == OP_POSTORDER);

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.walk_run = 1'b0;
		cmd.flush    = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start && is_trav && !stat.cnt_zero) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_run = 1'b1;
				if (stat.walk_done) begin
					state_d = S_DRAIN;
				end
			end
			// the last read is landing in the hold register
			S_DRAIN: begin
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/cts_dp.sv
module cts_dp
	import cts_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cts_cmd_t           cmd,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	output cts_stat_t          stat,
	output logic               strobe,
	output logic signed [31:0] item,
	output logic [1:0]         status,
	output logic               last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = IDX_W + 2;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cur_q;
	logic [1:0]       ph_q;
	logic [2:0]       mode_q;

	logic [CW-1:0]    left_ix;
	logic [CW-1:0]    right_ix;
	logic [CW-1:0]    count_x;
	logic             left_ok;
	logic             right_ok;
	logic [IDX_W-1:0] cur_m1;
	logic [IDX_W-1:0] parent;
	logic             emit;
	logic             full;
	logic             single;
	logic [1:0]       single_st;
	logic             wr_en;

	logic             emit_s1;
	logic [31:0]      rdata;
	logic [31:0]      pend_q;
	logic             pend_v_q;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign count_x  = CW'(count_q);
	assign left_ix  = CW'({cur_q, 1'b1});
	assign right_ix = left_ix + CW'(1);
	assign left_ok  = (left_ix < count_x);
	assign right_ok = (right_ix < count_x);
	assign cur_m1   = cur_q - IDX_W'(1);
	assign parent   = cur_m1 >> 1;

	assign stat.cnt_zero  = (count_q == '0);
	assign stat.walk_done = (ph_q == PH_FROM_RIGHT) && (cur_q == '0);

	always_comb begin
		case (ph_q)
			PH_DOWN:       emit = (mode_q == OP_PREORDER);
			PH_FROM_LEFT:  emit = (mode_q == OP_INORDER);
			PH_FROM_RIGHT: emit = (mode_q == OP_POSTORDER);
			default:       emit = 1'b0;
		endcase
	end

	// single-result operations and the empty traversal
	always_comb begin
		single    = 1'b1;
		single_st = ST_OK;
		wr_en     = 1'b0;
		case (op)
			OP_INSERT: begin
				single_st = full ? ST_FULL : ST_OK;
				wr_en     = cmd.accept && !full;
			end
			OP_DELETE: begin
				single_st = stat.cnt_zero ? ST_EMPTY : ST_OK;
			end
			OP_INORDER, OP_PREORDER, OP_POSTORDER: begin
				single    = stat.cnt_zero;
				single_st = ST_EMPTY;
			end
			default: begin
				single_st = ST_OK;
			end
		endcase
	end

	cts_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(value),
		.raddr(cur_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			emit_s1  <= 1'b0;
			pend_v_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			emit_s1 <= cmd.walk_run && emit;
			if (cmd.accept) begin
				if (op == OP_INSERT && !full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (op == OP_DELETE && !stat.cnt_zero) begin
					count_q <= count_q - CNT_W'(1);
				end
				strobe <= single;
			end else if (emit_s1) begin
				strobe   <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				strobe   <= 1'b1;
				pend_v_q <= 1'b0;
			end else begin
				strobe <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item   <= '0;
			status <= single_st;
			last   <= 1'b1;
			mode_q <= op;
			cur_q  <= '0;
			ph_q   <= PH_DOWN;
		end else begin
			if (emit_s1) begin
				item   <= pend_q;
				status <= ST_OK;
				last   <= 1'b0;
				pend_q <= rdata;
			end else if (cmd.flush) begin
				item   <= pend_q;
				status <= ST_OK;
				last   <= 1'b1;
			end
			if (cmd.walk_run) begin
				case (ph_q)
					PH_DOWN: begin
						if (left_ok) begin
							cur_q <= left_ix[IDX_W-1:0];
						end else begin
							ph_q <= PH_FROM_LEFT;
						end
					end
					PH_FROM_LEFT: begin
						if (right_ok) begin
							cur_q <= right_ix[IDX_W-1:0];
							ph_q  <= PH_DOWN;
						end else begin
							ph_q <= PH_FROM_RIGHT;
						end
					end
					PH_FROM_RIGHT: begin
						if (cur_q != '0) begin
							cur_q <= parent;
							ph_q  <= cur_q[0] ? PH_FROM_LEFT : PH_FROM_RIGHT;
						end
					end
					default: begin
						ph_q <= PH_FROM_RIGHT;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/complete_tree_store_traversal.sv
// Complete binary tree store. Values are kept heap-indexed in a RAM of
// CAPACITY entries with a node count: insert appends at the next level-order
// slot, delete drops the last slot, and the three depth-first traversals walk
// the tree and emit every stored value. An item transfers on a clock edge with
// start high and busy low. Each result appears for exactly one cycle with
// strobe high and must be taken then; the receiver cannot stall the block.
// Insert, delete, unused op codes and traversals of an empty tree give one
// result in the cycle after the transfer and keep busy low, so a new item may
// follow on the next cycle. A traversal holds busy while a walker with no
// stack steps through the heap indices one phase per cycle (arrive, back
// from left, back from right) for every node; a drain state then lets the
// last RAM read land and a flush state releases the held value as the final result.
module complete_tree_store_traversal
	import cts_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	output logic               strobe,
	output logic signed [31:0] item,
	output logic [1:0]         status,
	output logic               last
);

	cts_cmd_t  cmd;
	cts_stat_t stat;

	// sequence each transfer: single-result ops, then the walk and the drain
	cts_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	// hold the node count, the value RAM, the walker and the result register
	cts_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.op    (op),
		.value (value),
		.stat  (stat),
		.strobe(strobe),
		.item  (item),
		.status(status),
		.last  (last)
	);

endmodule

>>> bench/complete_tree_store_traversal_test.sv
`timescale 1ns / 100ps

module complete_tree_store_traversal_test;
	import cts_pkg::*;

	localparam int CAPACITY = 64;
	// op codes past postorder carry no operation; the block just acknowledges them
	localparam logic [2:0] OP_SPARE_FIRST = OP_POSTORDER + 3'd1;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	// directed part plus random episodes, at least 340 transfers in all
	localparam int TOTAL_ITEMS  = 340;
	// the limit allows far more than every item being a full walk followed by
	// the longest idle gap
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_LIMIT  = 20;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
	} tree_cmd_t;

	typedef struct packed {
		logic signed [31:0] item;
		logic [1:0]         status;
		logic               fin;
	} tree_result_t;

	typedef enum logic [1:0] {ARRIVE, LEFT_DONE, RIGHT_DONE} walk_step_e;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic [2:0]         op     = OP_INSERT;
	logic signed [31:0] value  = '0;
	logic               busy;
	logic               strobe;
	logic signed [31:0] item;
	logic [1:0]         status;
	logic               last;

	complete_tree_store_traversal #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.value  (value),
		.strobe (strobe),
		.item   (item),
		.status (status),
		.last   (last)
	);

	// commands waiting for the driver, and results the block still owes us
	tree_cmd_t    cmd_queue[$];
	tree_result_t awaited_results[$];

	// our own copy of the tree: heap-indexed values and the node count
	logic signed [31:0] node_vals[CAPACITY];
	int unsigned        node_total = 0;

	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;
	int unsigned idle_left     = 0;
	int unsigned calm_left     = 0;
	int unsigned gen_fill      = 0;
	int unsigned n_transfers   = 0;
	int unsigned n_walks       = 0;
	int unsigned n_spare       = 0;
	int unsigned n_results     = 0;
	int unsigned n_full        = 0;
	int unsigned n_empty       = 0;
	int unsigned peak_fill     = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void push_result(logic signed [31:0] v, logic [1:0] st, logic fin);
		tree_result_t r;
		r.item   = v;
		r.status = st;
		r.fin    = fin;
		awaited_results.push_back(r);
	endfunction

	// Stackless depth-first walk over the heap indices: descend left first,
	// then right, then climb back to the parent. Emit at the step that the
	// requested order asks for.
	function automatic void walk_tree(logic [2:0] order);
		int unsigned idx;
		walk_step_e  step;
		bit          done;
		idx  = 0;
		step = ARRIVE;
		done = 1'b0;
		while (!done) begin
			case (step)
				ARRIVE: begin
					if (order == OP_PREORDER)
						push_result(node_vals[idx], ST_OK, 1'b0);
					if (2 * idx + 1 < node_total)
						idx = 2 * idx + 1;
					else
						step = LEFT_DONE;
				end
				LEFT_DONE: begin
					if (order == OP_INORDER)
						push_result(node_vals[idx], ST_OK, 1'b0);
					if (2 * idx + 2 < node_total) begin
						idx  = 2 * idx + 2;
						step = ARRIVE;
					end else begin
						step = RIGHT_DONE;
					end
				end
				default: begin
					if (order == OP_POSTORDER)
						push_result(node_vals[idx], ST_OK, 1'b0);
					if (idx == 0) begin
						done = 1'b1;
					end else begin
						// odd index is a left child
						step = (idx % 2 == 1) ? LEFT_DONE : RIGHT_DONE;
						idx  = (idx - 1) / 2;
					end
				end
			endcase
		end
	endfunction

	// Apply one accepted command to the tree copy and queue what it yields.
	function automatic void tree_apply(logic [2:0] cmd, logic signed [31:0] val);
		tree_result_t tail;
		case (cmd)
			OP_INSERT: begin
				if (node_total >= CAPACITY) begin
					push_result('0, ST_FULL, 1'b1);
				end else begin
					node_vals[node_total] = val;
					node_total++;
					if (node_total > peak_fill)
						peak_fill = node_total;
					push_result('0, ST_OK, 1'b1);
				end
			end
			OP_DELETE: begin
				if (node_total == 0) begin
					push_result('0, ST_EMPTY, 1'b1);
				end else begin
					node_total--;
					push_result('0, ST_OK, 1'b1);
				end
			end
			OP_INORDER, OP_PREORDER, OP_POSTORDER: begin
				n_walks++;
				if (node_total == 0) begin
					push_result('0, ST_EMPTY, 1'b1);
				end else begin
					walk_tree(cmd);
					// mark the final value of the walk
					tail = awaited_results.pop_back();
					tail.fin = 1'b1;
					awaited_results.push_back(tail);
				end
			end
			default: begin
				n_spare++;
				push_result('0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	// Idle length after a transfer: mostly none or short, now and then long,
	// and every so often a calm stretch of back-to-back commands.
	function automatic int unsigned draw_gap();
		int unsigned r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Insert values lean on the sign bit and the all-ones and all-zeros patterns.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_walk();
		return 3'(OP_INORDER + $urandom_range(0, 2));
	endfunction

	// Queue a command; track the fill level only to steer the directed climb and drain.
	task automatic queue_cmd(input logic [2:0] cmd, input logic signed [31:0] val);
		tree_cmd_t c;
		c.op    = cmd;
		c.value = val;
		cmd_queue.push_back(c);
		if (cmd == OP_INSERT && gen_fill < CAPACITY)
			gen_fill++;
		else if (cmd == OP_DELETE && gen_fill != 0)
			gen_fill--;
	endtask

	// Driver: present the next command, hold it while busy, idle between.
	always @(posedge clk) begin : drive
		tree_cmd_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				tree_apply(op, value);
				n_transfers++;
			end
			if (!start || !busy) begin
				if (idle_left != 0) begin
					idle_left--;
					start <= 1'b0;
					// scramble the payload while nothing is offered
					op    <= 3'($urandom);
					value <= $urandom;
				end else if (cmd_queue.size() != 0) begin
					nxt = cmd_queue.pop_front();
					op    <= nxt.op;
					value <= nxt.value;
					start <= 1'b1;
					idle_left = draw_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobe must match the oldest result still owed.
	always @(posedge clk) begin : watch
		tree_result_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result item=%0d status=%0d last=%b",
					item, status, last));
			end else begin
				want = awaited_results.pop_front();
				n_results++;
				if (want.status == ST_FULL)
					n_full++;
				if (want.status == ST_EMPTY)
					n_empty++;
				if (item !== want.item || status !== want.status || last !== want.fin)
					report_mismatch($sformatf(
						"got item=%0d status=%0d last=%b, want item=%0d status=%0d last=%b",
						item, status, last, want.item, want.status, want.fin));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, awaited_results.size());
			$display("[complete_tree_store_traversal] ERROR");
			$finish;
		end
	end

	initial begin : run
		int unsigned span;
		int unsigned r;
		bit          grow;

		// Directed: every operation on an empty tree, the spare op codes,
		// extreme values, then all three walks over a tree that is not perfect.
		queue_cmd(OP_INORDER, $urandom);
		queue_cmd(OP_PREORDER, $urandom);
		queue_cmd(OP_POSTORDER, $urandom);
		queue_cmd(OP_DELETE, $urandom);
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
			queue_cmd(3'(c), $urandom);
		queue_cmd(OP_INSERT, 32'sh8000_0000);
		queue_cmd(OP_INSERT, 32'sh7fff_ffff);
		queue_cmd(OP_INSERT, '0);
		queue_cmd(OP_INSERT, '1);
		queue_cmd(OP_INSERT, 32'sh5555_5555);
		queue_cmd(OP_INSERT, 32'shaaaa_aaaa);
		queue_cmd(OP_INORDER, '0);
		queue_cmd(OP_PREORDER, '1);
		queue_cmd(OP_POSTORDER, '0);
		queue_cmd(OP_DELETE, '1);
		queue_cmd(OP_INORDER, $urandom);
		queue_cmd(OP_POSTORDER, $urandom);

		// Climb to capacity, push against it, walk the full tree three ways.
		while (gen_fill < CAPACITY)
			queue_cmd(OP_INSERT, pick_value());
		queue_cmd(OP_INSERT, pick_value());
		queue_cmd(OP_INSERT, pick_value());
		queue_cmd(OP_INORDER, $urandom);
		queue_cmd(OP_PREORDER, $urandom);
		queue_cmd(OP_POSTORDER, $urandom);

		// Drain back to empty with walks sprinkled in, then poke the empty tree.
		while (gen_fill != 0) begin
			queue_cmd(OP_DELETE, $urandom);
			if ($urandom_range(0, 9) == 0)
				queue_cmd(pick_walk(), $urandom);
		end
		queue_cmd(OP_DELETE, $urandom);
		queue_cmd(pick_walk(), $urandom);

		// Random episodes that lean toward growing or shrinking the tree.
		while (cmd_queue.size() < TOTAL_ITEMS) begin
			grow = $urandom_range(0, 1);
			span = $urandom_range(15, 50);
			repeat (span) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					queue_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom);
				else if (r < 28)
					queue_cmd(pick_walk(), $urandom);
				else if (r < (grow ? 88 : 40))
					queue_cmd(OP_INSERT, pick_value());
				else
					queue_cmd(OP_DELETE, $urandom);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every command to transfer and every owed result to arrive
		while (cmd_queue.size() != 0 || start || awaited_results.size() != 0)
			@(negedge clk);
		// hold a little longer to catch stray strobes
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d commands transferred (%0d walks, %0d spare op codes), %0d results checked",
			n_transfers, n_walks, n_spare, n_results);
		$display("tree peaked at %0d nodes; %0d full rejections, %0d empty-tree results",
			peak_fill, n_full, n_empty);
		if (error_count == 0)
			$display("[complete_tree_store_traversal] OK");
		else
			$display("[complete_tree_store_traversal] ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/cts_pkg.sv
rtl/cts_ram.sv
rtl/cts_ctrl.sv
rtl/cts_dp.sv
rtl/complete_tree_store_traversal.sv
bench/complete_tree_store_traversal_test.sv
